### src/qadm_pkg.sv
// shared types, register indexes and constants for the queue admission block
package qadm_pkg;

  localparam int FIELD_W       = 16;
  localparam int PROB_W        = 17;
  localparam int OUT_COUNT_W   = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 17;
  localparam int IN_DATA_W     = 32;
  localparam int OUT_DATA_W    = 72;

  localparam int DEPTH_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 32;

  localparam logic [PROB_W-1:0]  PROB_ONE    = 17'h10000;
  localparam logic [FIELD_W-1:0] LIMIT_RESET = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RED_PROB = 3'd4;

  typedef enum logic [1:0] {
    POL_UNLIMITED = 2'd0,
    POL_FIFO      = 2'd1,
    POL_RED       = 2'd2,
    POL_TOKEN     = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    CAUSE_ADMIT = 2'd0,
    CAUSE_TAIL  = 2'd1,
    CAUSE_EARLY = 2'd2
  } cause_t;

  typedef struct packed {
    policy_t              policy_mode;
    logic [FIELD_W-1:0]   queue_limit;
    logic [FIELD_W-1:0]   red_min_threshold;
    logic [FIELD_W-1:0]   red_max_threshold;
    logic [PROB_W-1:0]    red_max_probability;
  } cfg_t;

endpackage

### src/qadm_cfg_regs.sv
// configuration register file with counter clear on policy writes
module qadm_cfg_regs #(
  parameter int DEPTH_BITS = qadm_pkg::DEPTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [qadm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qadm_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output qadm_pkg::cfg_t                   cfg,
  output logic                             cnt_clear
);

  localparam int DW = (DEPTH_BITS < qadm_pkg::FIELD_W) ? DEPTH_BITS : qadm_pkg::FIELD_W;
  localparam logic [qadm_pkg::FIELD_W-1:0] DEPTH_MASK =
    {qadm_pkg::FIELD_W{1'b1}} >> (qadm_pkg::FIELD_W - DW);

  qadm_pkg::cfg_t cfg_r, cfg_nxt;
  logic [qadm_pkg::FIELD_W-1:0] wdata_depth;

  assign wdata_depth = cfg_wdata[qadm_pkg::FIELD_W-1:0] & DEPTH_MASK;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        qadm_pkg::REG_POLICY:   cfg_nxt.policy_mode = qadm_pkg::policy_t'(cfg_wdata[1:0]);
        qadm_pkg::REG_LIMIT:    cfg_nxt.queue_limit = wdata_depth;
        qadm_pkg::REG_RED_MIN:  cfg_nxt.red_min_threshold = wdata_depth;
        qadm_pkg::REG_RED_MAX:  cfg_nxt.red_max_threshold = wdata_depth;
        qadm_pkg::REG_RED_PROB: cfg_nxt.red_max_probability = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy_mode         <= qadm_pkg::POL_UNLIMITED;
      cfg_r.queue_limit         <= qadm_pkg::LIMIT_RESET & DEPTH_MASK;
      cfg_r.red_min_threshold   <= '0;
      cfg_r.red_max_threshold   <= '0;
      cfg_r.red_max_probability <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg       = cfg_r;
  assign cnt_clear = cfg_wr_en && (cfg_index == qadm_pkg::REG_POLICY);

endmodule

### src/qadm_decide.sv
// admission decision for one request under the selected policy
module qadm_decide (
  input  qadm_pkg::cfg_t                  cfg,
  input  logic [qadm_pkg::FIELD_W-1:0]    queue_depth,
  input  logic [qadm_pkg::FIELD_W-1:0]    random_sample,
  output qadm_pkg::cause_t                cause
);

  localparam int FW = qadm_pkg::FIELD_W;
  localparam int PW = qadm_pkg::PROB_W;

  logic [PW-1:0]      prob_sat;
  logic [FW-1:0]      span;
  logic [FW-1:0]      over;
  logic [2*FW-1:0]    lhs;
  logic [PW+FW-1:0]   rhs;
  logic               below_limit;
  logic               slope_drop;
  logic               flat_drop;
  qadm_pkg::cause_t   red_cause;

  // probability above one saturates to one
  assign prob_sat = (cfg.red_max_probability > qadm_pkg::PROB_ONE) ?
                    qadm_pkg::PROB_ONE : cfg.red_max_probability;

  assign span = cfg.red_max_threshold - cfg.red_min_threshold;
  assign over = queue_depth - cfg.red_min_threshold;
  assign lhs  = (2*FW)'(random_sample) * (2*FW)'(span);
  assign rhs  = (PW+FW)'(prob_sat) * (PW+FW)'(over);

  assign slope_drop  = {{(PW-FW){1'b0}}, lhs} < rhs;
  assign flat_drop   = {{(PW-FW){1'b0}}, random_sample} < prob_sat;
  assign below_limit = queue_depth < cfg.queue_limit;

  always_comb begin
    if (queue_depth < cfg.red_min_threshold) begin
      red_cause = qadm_pkg::CAUSE_ADMIT;
    end else if (queue_depth < cfg.red_max_threshold) begin
      red_cause = slope_drop ? qadm_pkg::CAUSE_EARLY : qadm_pkg::CAUSE_ADMIT;
    end else if (below_limit) begin
      red_cause = flat_drop ? qadm_pkg::CAUSE_EARLY : qadm_pkg::CAUSE_ADMIT;
    end else begin
      red_cause = qadm_pkg::CAUSE_TAIL;
    end
  end

  always_comb begin
    case (cfg.policy_mode)
      qadm_pkg::POL_FIFO,
      qadm_pkg::POL_TOKEN: cause = below_limit ? qadm_pkg::CAUSE_ADMIT : qadm_pkg::CAUSE_TAIL;
      qadm_pkg::POL_RED:   cause = red_cause;
      default:             cause = qadm_pkg::CAUSE_ADMIT;
    endcase
  end

endmodule

### src/queue_admission_red_taildrop.sv
// top level of the queue admission block: request register, decision, result register
//
// Each request on the in_ stream carries the current queue depth and a uniform
// random sample; each one yields exactly one result on the out_ stream with the
// admit flag, the drop cause and both drop counters as they stand after it.
// Policy: unlimited, fifo tail drop, random early detection or token tail drop.
// The request register loads when a request is accepted, and the decision logic
// (a 16x16 and a 17x16 multiply with compares) then loads the result register,
// which drives out_tvalid; that load waits while a result is held with out_tready low.
// While out_tready stays high a new request is taken every cycle, so sustained
// throughput is one request per clock.
// If out_tready is low the result register holds and one more request waits in
// the request register; in_tready drops only when both are full.
// Configuration is a plain write port; a write to policy_mode clears both drop
// counters. Writes are expected only while no request is in flight.
// Synchronous reset loads the register defaults, zeroes the counters and
// empties both stages.
module queue_admission_red_taildrop #(
  parameter int DEPTH_BITS = qadm_pkg::DEPTH_BITS_DEF,
  parameter int COUNT_BITS = qadm_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // fields from bit 0: queue_depth[15:0], random_sample[31:16]
  input  logic [qadm_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // fields from bit 0: admit[0], drop_cause[2:1], tail_drop_total[34:3],
  // early_drop_total[66:35], zero pad[71:67]
  output logic [qadm_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_wr_en,
  input  logic [qadm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [qadm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int FW = qadm_pkg::FIELD_W;
  localparam int OW = qadm_pkg::OUT_COUNT_W;
  localparam int DW = (DEPTH_BITS < FW) ? DEPTH_BITS : FW;
  localparam logic [FW-1:0] DEPTH_MASK = {FW{1'b1}} >> (FW - DW);
  localparam int PAD_W = qadm_pkg::OUT_DATA_W - (3 + 2 * OW);

  qadm_pkg::cfg_t    cfg;
  logic              cnt_clear;
  qadm_pkg::cause_t  cause;

  logic              req_valid_r;
  logic [FW-1:0]     req_depth_r;
  logic [FW-1:0]     req_rnd_r;

  logic              out_valid_r;
  logic              admit_r;
  qadm_pkg::cause_t  cause_r;
  logic [OW-1:0]     tail_total_r;
  logic [OW-1:0]     early_total_r;

  logic [COUNT_BITS-1:0] tail_cnt_r, tail_cnt_nxt;
  logic [COUNT_BITS-1:0] early_cnt_r, early_cnt_nxt;

  logic              in_accept;
  logic              out_load;

  qadm_cfg_regs #(
    .DEPTH_BITS(DEPTH_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cnt_clear (cnt_clear)
  );

  qadm_decide u_decide (
    .cfg           (cfg),
    .queue_depth   (req_depth_r),
    .random_sample (req_rnd_r),
    .cause         (cause)
  );

  assign out_load  = req_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !req_valid_r || out_load;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_accept) begin
      req_valid_r <= 1'b1;
    end else if (out_load) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_depth_r <= in_tdata[FW-1:0] & DEPTH_MASK;
      req_rnd_r   <= in_tdata[2*FW-1:FW];
    end
  end

  always_comb begin
    tail_cnt_nxt  = tail_cnt_r;
    early_cnt_nxt = early_cnt_r;
    if (out_load) begin
      case (cause)
        qadm_pkg::CAUSE_TAIL:  tail_cnt_nxt  = tail_cnt_r + COUNT_BITS'(1);
        qadm_pkg::CAUSE_EARLY: early_cnt_nxt = early_cnt_r + COUNT_BITS'(1);
        default: begin
          tail_cnt_nxt  = tail_cnt_r;
          early_cnt_nxt = early_cnt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cnt_clear) begin
      tail_cnt_r  <= '0;
      early_cnt_r <= '0;
    end else begin
      tail_cnt_r  <= tail_cnt_nxt;
      early_cnt_r <= early_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      admit_r       <= (cause == qadm_pkg::CAUSE_ADMIT);
      cause_r       <= cause;
      tail_total_r  <= OW'(tail_cnt_nxt);
      early_total_r <= OW'(early_cnt_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, early_total_r, tail_total_r, cause_r, admit_r};

endmodule

### test/tb_queue_admission_red_taildrop.sv
// testbench for queue_admission_red_taildrop: directed and random requests checked against a predictor
module tb_queue_admission_red_taildrop;

  typedef struct {
    logic              admit;
    qadm_pkg::cause_t  cause;
    logic [31:0]       tail_total;
    logic [31:0]       early_total;
  } admission_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [qadm_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [qadm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [qadm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [qadm_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor copy of the registers and drop counters
  qadm_pkg::policy_t            pol_mode;
  logic [qadm_pkg::FIELD_W-1:0] lim;
  logic [qadm_pkg::FIELD_W-1:0] red_lo;
  logic [qadm_pkg::FIELD_W-1:0] red_hi;
  logic [qadm_pkg::PROB_W-1:0]  red_p;
  logic [31:0]                  tail_cnt;
  logic [31:0]                  early_cnt;

  admission_t expected_q[$];
  admission_t want_res;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int n_req = 0;
  int n_admit = 0;
  int n_tail = 0;
  int n_early = 0;
  int n_cfg = 0;

  queue_admission_red_taildrop i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results pending", expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with no request pending", out_tdata[31:0], '0);
      end else begin
        want_res = expected_q.pop_front();
        if (out_tdata[0] !== want_res.admit)
          report_mismatch("admit", out_tdata[0], want_res.admit);
        if (out_tdata[2:1] !== want_res.cause)
          report_mismatch("drop_cause", out_tdata[2:1], want_res.cause);
        if (out_tdata[34:3] !== want_res.tail_total)
          report_mismatch("tail_drop_total", out_tdata[34:3], want_res.tail_total);
        if (out_tdata[66:35] !== want_res.early_total)
          report_mismatch("early_drop_total", out_tdata[66:35], want_res.early_total);
      end
    end
  end

  task automatic reset_model();
    pol_mode  = qadm_pkg::POL_UNLIMITED;
    lim       = qadm_pkg::LIMIT_RESET;
    red_lo    = '0;
    red_hi    = '0;
    red_p     = '0;
    tail_cnt  = '0;
    early_cnt = '0;
  endtask

  function automatic admission_t decide_admission(input logic [15:0] depth,
                                                  input logic [15:0] rnd);
    admission_t        res;
    qadm_pkg::cause_t  c;
    logic [63:0]       p;
    logic [63:0]       span;
    logic [63:0]       over;
    p = (red_p > qadm_pkg::PROB_ONE) ? 64'(qadm_pkg::PROB_ONE) : 64'(red_p);
    case (pol_mode)
      qadm_pkg::POL_FIFO, qadm_pkg::POL_TOKEN: begin
        c = (depth < lim) ? qadm_pkg::CAUSE_ADMIT : qadm_pkg::CAUSE_TAIL;
      end
      qadm_pkg::POL_RED: begin
        if (depth < red_lo) begin
          c = qadm_pkg::CAUSE_ADMIT;
        end else if (depth < red_hi) begin
          span = 64'(red_hi) - 64'(red_lo);
          over = 64'(depth) - 64'(red_lo);
          c = (64'(rnd) * span < p * over) ? qadm_pkg::CAUSE_EARLY : qadm_pkg::CAUSE_ADMIT;
        end else if (depth < lim) begin
          c = (64'(rnd) < p) ? qadm_pkg::CAUSE_EARLY : qadm_pkg::CAUSE_ADMIT;
        end else begin
          c = qadm_pkg::CAUSE_TAIL;
        end
      end
      default: c = qadm_pkg::CAUSE_ADMIT;
    endcase
    if (c == qadm_pkg::CAUSE_TAIL) tail_cnt++;
    else if (c == qadm_pkg::CAUSE_EARLY) early_cnt++;
    res.admit       = (c == qadm_pkg::CAUSE_ADMIT);
    res.cause       = c;
    res.tail_total  = tail_cnt;
    res.early_total = early_cnt;
    return res;
  endfunction

  // only called while nothing is in flight
  task automatic write_reg(input logic [qadm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qadm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      qadm_pkg::REG_POLICY: begin
        pol_mode  = qadm_pkg::policy_t'(val[1:0]);
        tail_cnt  = '0;
        early_cnt = '0;
      end
      qadm_pkg::REG_LIMIT:    lim    = val[qadm_pkg::FIELD_W-1:0];
      qadm_pkg::REG_RED_MIN:  red_lo = val[qadm_pkg::FIELD_W-1:0];
      qadm_pkg::REG_RED_MAX:  red_hi = val[qadm_pkg::FIELD_W-1:0];
      qadm_pkg::REG_RED_PROB: red_p  = val[qadm_pkg::PROB_W-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_request(input logic [15:0] depth, input logic [15:0] rnd);
    admission_t res;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rnd, depth};
    do @(posedge clk); while (!in_tready);
    res = decide_admission(depth, rnd);
    expected_q.push_back(res);
    n_req++;
    case (res.cause)
      qadm_pkg::CAUSE_TAIL:  n_tail++;
      qadm_pkg::CAUSE_EARLY: n_early++;
      default:               n_admit++;
    endcase
  endtask

  // stop sending and hold off until every pending result is back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_red(input int lo, input int hi, input int lm, input int p);
    write_reg(qadm_pkg::REG_RED_MIN, qadm_pkg::CFG_DATA_W'(lo));
    write_reg(qadm_pkg::REG_RED_MAX, qadm_pkg::CFG_DATA_W'(hi));
    write_reg(qadm_pkg::REG_LIMIT, qadm_pkg::CFG_DATA_W'(lm));
    write_reg(qadm_pkg::REG_RED_PROB, qadm_pkg::CFG_DATA_W'(p));
  endtask

  task automatic test_reset_defaults();
    send_request(16'h0000, 16'h0000);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'h5A5A, 16'hA5A5);
    drain();
  endtask

  task automatic test_tail_drop_policies();
    qadm_pkg::policy_t pols[2] = '{qadm_pkg::POL_FIFO, qadm_pkg::POL_TOKEN};
    foreach (pols[i]) begin
      write_reg(qadm_pkg::REG_POLICY, qadm_pkg::CFG_DATA_W'(pols[i]));
      write_reg(qadm_pkg::REG_LIMIT, '0);
      send_request(16'h0000, 16'h1234);
      drain();
      write_reg(qadm_pkg::REG_LIMIT, qadm_pkg::CFG_DATA_W'(qadm_pkg::LIMIT_RESET));
      send_request(16'hFFFE, 16'hFFFF);
      send_request(16'hFFFF, 16'h0000);
      drain();
    end
  endtask

  task automatic test_red_regions();
    write_reg(qadm_pkg::REG_POLICY, qadm_pkg::CFG_DATA_W'(qadm_pkg::POL_RED));
    set_red(100, 200, 300, 32768);
    send_request(16'd99, 16'd0);
    send_request(16'd100, 16'd0);
    send_request(16'd150, 16'd0);
    send_request(16'd150, 16'hFFFF);
    send_request(16'd199, 16'd32767);
    send_request(16'd200, 16'd32767);
    send_request(16'd200, 16'd32768);
    send_request(16'd299, 16'd0);
    send_request(16'd300, 16'd0);
    send_request(16'hFFFF, 16'hFFFF);
    drain();
  endtask

  // min above the limit: low depths are still admitted
  task automatic test_min_above_limit();
    set_red(500, 600, 100, 65536);
    send_request(16'd300, 16'd0);
    send_request(16'd550, 16'd0);
    drain();
  endtask

  task automatic test_prob_saturation();
    set_red(100, 200, 300, 131071);
    send_request(16'd250, 16'hFFFF);
    drain();
    write_reg(qadm_pkg::REG_RED_PROB, '0);
    send_request(16'd250, 16'd0);
    drain();
  endtask

  // policy write clears both counters; unused indexes change nothing
  task automatic test_counter_clear();
    write_reg(qadm_pkg::REG_POLICY, qadm_pkg::CFG_DATA_W'(qadm_pkg::POL_RED) | 17'h1FFFC);
    for (int i = int'(qadm_pkg::REG_RED_PROB) + 1; i < (1 << qadm_pkg::CFG_IDX_W); i++)
      write_reg(qadm_pkg::CFG_IDX_W'(i), qadm_pkg::CFG_DATA_W'($urandom));
    send_request(16'hFFFF, 16'h0000);
    drain();
  endtask

  function automatic logic [15:0] clamp16(input int v);
    if (v < 0) return 16'h0000;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_depth();
    int d;
    case ($urandom_range(0, 7))
      0: d = int'(red_lo) + int'($urandom_range(0, 8)) - 4;
      1: d = int'(red_hi) + int'($urandom_range(0, 8)) - 4;
      2: d = int'(lim) + int'($urandom_range(0, 8)) - 4;
      3, 4: d = int'($urandom_range(red_lo, red_hi));
      5: d = $urandom_range(0, 1) ? 0 : 65535;
      default: d = int'($urandom_range(0, 65535));
    endcase
    return clamp16(d);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return clamp16(int'(red_p) + int'($urandom_range(0, 4)) - 2);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic apply_random_settings();
    int lo;
    int hi;
    int lm;
    logic [qadm_pkg::CFG_DATA_W-1:0] val;
    lo = int'($urandom_range(0, 60000));
    hi = lo + int'($urandom_range(0, 3000));
    lm = hi + int'($urandom_range(0, 3000));
    case ($urandom_range(0, 7))
      0: lm = 0;
      1: lm = 65535;
      2: hi = int'($urandom_range(0, 65535));
      3: lm = int'($urandom_range(0, lo));
      default: ;
    endcase
    if ($urandom_range(0, 2) != 0) begin
      val = qadm_pkg::CFG_DATA_W'($urandom);
      val[1:0] = $urandom_range(0, 1) ? 2'(qadm_pkg::POL_RED) : 2'($urandom_range(0, 3));
      write_reg(qadm_pkg::REG_POLICY, val);
    end
    // bit 16 is outside the 16-bit registers and must be ignored
    write_reg(qadm_pkg::REG_LIMIT, {1'($urandom_range(0, 1)), clamp16(lm)});
    write_reg(qadm_pkg::REG_RED_MIN, {1'($urandom_range(0, 1)), clamp16(lo)});
    write_reg(qadm_pkg::REG_RED_MAX, {1'($urandom_range(0, 1)), clamp16(hi)});
    case ($urandom_range(0, 5))
      0: val = '0;
      1: val = qadm_pkg::CFG_DATA_W'(qadm_pkg::PROB_ONE);
      2: val = qadm_pkg::CFG_DATA_W'($urandom_range(65537, 131071));
      default: val = qadm_pkg::CFG_DATA_W'($urandom_range(0, 65536));
    endcase
    write_reg(qadm_pkg::REG_RED_PROB, val);
    if ($urandom_range(0, 9) == 0)
      write_reg(qadm_pkg::CFG_IDX_W'($urandom_range(int'(qadm_pkg::REG_RED_PROB) + 1, 7)),
                qadm_pkg::CFG_DATA_W'($urandom));
  endtask

  task automatic test_random_traffic(input int n_items);
    int left;
    int blk;
    left = n_items;
    while (left > 0) begin
      apply_random_settings();
      blk = $urandom_range(30, 90);
      if (blk > left) blk = left;
      repeat (blk) begin
        send_request(pick_depth(), pick_sample());
        if ($urandom_range(0, 60) == 0) drain();
      end
      drain();
      left -= blk;
    end
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 37;
    recv_stall_pct = 76;
    test_reset_defaults();
    test_tail_drop_policies();
    test_red_regions();
    test_min_above_limit();
    test_prob_saturation();
    test_counter_clear();
    test_random_traffic(510);

    send_idle_pct  = 76;
    recv_stall_pct = 37;
    test_random_traffic(510);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_traffic(510);

    drain();
    repeat (8) @(posedge clk);
    $display("run covered %0d requests and %0d register writes over all four policies",
             n_req, n_cfg);
    $display("admitted %0d, tail drops %0d, early drops %0d", n_admit, n_tail, n_early);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
src/qadm_pkg.sv
src/qadm_cfg_regs.sv
src/qadm_decide.sv
src/queue_admission_red_taildrop.sv
test/tb_queue_admission_red_taildrop.sv
